// ----- rtl/smbs_pkg.sv -----
// Shared types and constants for the SPI master byte shifter.
`default_nettype none

package smbs_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned BITCNT_W = 3;

  localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
  localparam logic [BITCNT_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic {
    ITEM_TICK  = 1'b0,
    ITEM_START = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [BYTE_W-1:0] load_byte;
    logic              last;
    logic              miso;
  } item_t;

  typedef enum logic [1:0] {
    PH_SCK_LOW  = 2'd0,
    PH_MOSI     = 2'd1,
    PH_SCK_HIGH = 2'd2,
    PH_SAMPLE   = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ----- rtl/spi_master_byte_shifter_unit.sv -----
// Top level of the SPI master byte shifter (mode 3, MSB first).
// Each input transfer is one tick of the pin-level engine, and each tick gives exactly one
// result transfer holding the SCK, MOSI and busy levels after that tick, plus the received
// byte on the tick a byte completes. One transfer is taken per clock cycle while in_stall
// is low; its result passes through a two-entry queue and the engine's output register,
// and out_stall holds results without losing ticks until the queue fills. A byte occupies
// 32*(half_delay+1)+1 ticks counting its start tick and reports on its last tick.
// The half_delay register is written through the cfg port, which is always ready.
`default_nettype none

module spi_master_byte_shifter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [smbs_pkg::DELAY_W-1:0]  cfg_half_delay,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_start_req,
  input  wire logic                          in_tx_present,
  input  wire logic [smbs_pkg::BYTE_W-1:0]   in_tx_byte,
  input  wire logic                          in_last_byte,
  input  wire logic                          in_miso,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_sck,
  output logic                               out_mosi,
  output logic                               out_busy_res,
  output logic                               out_rx_valid,
  output logic [smbs_pkg::BYTE_W-1:0]        out_rx_byte,
  output logic                               out_rx_last
);

  smbs_pkg::item_t front_item;
  smbs_pkg::item_t head_item;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  smbs_front u_front (
    .start_req  (in_start_req),
    .tx_present (in_tx_present),
    .tx_byte    (in_tx_byte),
    .last_byte  (in_last_byte),
    .miso       (in_miso),
    .item       (front_item)
  );

  smbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  smbs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_half_delay (cfg_half_delay),
    .item_avail     (q_not_empty),
    .item           (head_item),
    .item_pop       (q_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_sck        (out_sck),
    .out_mosi       (out_mosi),
    .out_busy_res   (out_busy_res),
    .out_rx_valid   (out_rx_valid),
    .out_rx_byte    (out_rx_byte),
    .out_rx_last    (out_rx_last)
  );

endmodule

`default_nettype wire

// ----- rtl/smbs_front.sv -----
// Front end: classifies each incoming tick and builds the queued item.
`default_nettype none

module smbs_front (
  input  wire logic                      start_req,
  input  wire logic                      tx_present,
  input  wire logic [smbs_pkg::BYTE_W-1:0] tx_byte,
  input  wire logic                      last_byte,
  input  wire logic                      miso,
  output smbs_pkg::item_t                item
);

  always_comb begin
    item.kind      = start_req ? smbs_pkg::ITEM_START : smbs_pkg::ITEM_TICK;
    item.load_byte = tx_present ? tx_byte : smbs_pkg::IDLE_BYTE;
    item.last      = last_byte;
    item.miso      = miso;
  end

endmodule

`default_nettype wire

// ----- rtl/smbs_queue.sv -----
// Short queue that decouples the front end from the shift engine.
`default_nettype none

module smbs_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire smbs_pkg::item_t push_item,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output smbs_pkg::item_t head_item
);

  smbs_pkg::item_t mem_r [smbs_pkg::QUEUE_DEPTH];
  logic [smbs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [smbs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [smbs_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full      = (count_r == smbs_pkg::QCNT_W'(smbs_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == smbs_pkg::QPTR_W'(smbs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == smbs_pkg::QPTR_W'(smbs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smbs_pkg::QCNT_W'(smbs_pkg::QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("Queue count did not grow on a lone push.");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("Queue count did not shrink on a lone pop.");

endmodule

`default_nettype wire

// ----- rtl/smbs_back.sv -----
// Back end: the mode 3 shift engine and the registered result stage.
`default_nettype none

module smbs_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [smbs_pkg::DELAY_W-1:0] cfg_half_delay,
  input  wire logic                         item_avail,
  input  wire smbs_pkg::item_t              item,
  output logic                              item_pop,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              out_sck,
  output logic                              out_mosi,
  output logic                              out_busy_res,
  output logic                              out_rx_valid,
  output logic [smbs_pkg::BYTE_W-1:0]       out_rx_byte,
  output logic                              out_rx_last
);

  logic [smbs_pkg::DELAY_W-1:0]  half_delay_r;
  logic [smbs_pkg::BYTE_W-1:0]   shift_r, shift_nxt;
  logic [smbs_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  smbs_pkg::phase_t              phase_r, phase_nxt;
  logic [smbs_pkg::DELAY_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic                          active_r, active_nxt;
  logic                          sck_r, sck_nxt;
  logic                          mosi_r, mosi_nxt;
  logic                          final_r, final_nxt;
  logic                          rx_valid_nxt;
  logic [smbs_pkg::BYTE_W-1:0]   rx_byte_nxt;
  logic                          rx_last_nxt;

  logic                          out_valid_r;
  logic                          out_sck_r;
  logic                          out_mosi_r;
  logic                          out_busy_r;
  logic                          out_rx_valid_r;
  logic [smbs_pkg::BYTE_W-1:0]   out_rx_byte_r;
  logic                          out_rx_last_r;

  assign item_pop = item_avail && (!out_valid_r || !out_stall);

  always_comb begin
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    phase_nxt    = phase_r;
    tick_cnt_nxt = tick_cnt_r;
    active_nxt   = active_r;
    sck_nxt      = sck_r;
    mosi_nxt     = mosi_r;
    final_nxt    = final_r;
    rx_valid_nxt = 1'b0;
    rx_byte_nxt  = '0;
    rx_last_nxt  = 1'b0;
    if (!active_r) begin
      if (item.kind == smbs_pkg::ITEM_START) begin
        shift_nxt    = item.load_byte;
        final_nxt    = item.last;
        active_nxt   = 1'b1;
        bit_cnt_nxt  = '0;
        phase_nxt    = smbs_pkg::PH_SCK_LOW;
        tick_cnt_nxt = '0;
        sck_nxt      = 1'b0;
      end
    end else if (tick_cnt_r < half_delay_r) begin
      tick_cnt_nxt = tick_cnt_r + 1'b1;
    end else begin
      tick_cnt_nxt = '0;
      case (phase_r)
        smbs_pkg::PH_SCK_LOW: begin
          phase_nxt = smbs_pkg::PH_MOSI;
          mosi_nxt  = shift_r[smbs_pkg::BYTE_W-1];
        end
        smbs_pkg::PH_MOSI: begin
          phase_nxt = smbs_pkg::PH_SCK_HIGH;
          shift_nxt = {shift_r[smbs_pkg::BYTE_W-2:0], 1'b0};
          sck_nxt   = 1'b1;
        end
        smbs_pkg::PH_SCK_HIGH: begin
          phase_nxt = smbs_pkg::PH_SAMPLE;
          shift_nxt = {shift_r[smbs_pkg::BYTE_W-1:1], item.miso};
        end
        smbs_pkg::PH_SAMPLE: begin
          phase_nxt = smbs_pkg::PH_SCK_LOW;
          if (bit_cnt_r == smbs_pkg::LAST_BIT) begin
            active_nxt   = 1'b0;
            bit_cnt_nxt  = '0;
            rx_valid_nxt = 1'b1;
            rx_byte_nxt  = shift_r;
            rx_last_nxt  = final_r;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            sck_nxt     = 1'b0;
          end
        end
        default: begin
          phase_nxt = smbs_pkg::PH_SCK_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_delay_r <= '0;
    end else if (cfg_we) begin
      half_delay_r <= cfg_half_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      bit_cnt_r  <= '0;
      phase_r    <= smbs_pkg::PH_SCK_LOW;
      tick_cnt_r <= '0;
      active_r   <= 1'b0;
      sck_r      <= 1'b1;
      mosi_r     <= 1'b1;
      final_r    <= 1'b0;
    end else if (item_pop) begin
      shift_r    <= shift_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      phase_r    <= phase_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      active_r   <= active_nxt;
      sck_r      <= sck_nxt;
      mosi_r     <= mosi_nxt;
      final_r    <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_sck_r      <= sck_nxt;
      out_mosi_r     <= mosi_nxt;
      out_busy_r     <= active_nxt;
      out_rx_valid_r <= rx_valid_nxt;
      out_rx_byte_r  <= rx_byte_nxt;
      out_rx_last_r  <= rx_last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sck      = out_sck_r;
  assign out_mosi     = out_mosi_r;
  assign out_busy_res = out_busy_r;
  assign out_rx_valid = out_rx_valid_r;
  assign out_rx_byte  = out_rx_byte_r;
  assign out_rx_last  = out_rx_last_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rx_valid_r) |-> !out_busy_r)
    else $error("Completed byte reported while still busy.");

  a_idle_sck_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_r) |-> out_sck_r)
    else $error("SCK low while the engine is idle.");

  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rx_valid_r) |-> (out_rx_byte_r == '0 && !out_rx_last_r))
    else $error("Receive fields set without a completed byte.");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && !active_r && item.kind == smbs_pkg::ITEM_START) |=>
      (active_r && !sck_r && bit_cnt_r == '0))
    else $error("Start request did not begin a byte.");

endmodule

`default_nettype wire

// ----- dv/spi_master_byte_shifter_unit_test.sv -----
// Self-checking testbench for the SPI master byte shifter with a tick-level pin predictor.
module spi_master_byte_shifter_unit_test;
  import smbs_pkg::*;

  typedef struct {
    bit              start;
    bit              present;
    bit [BYTE_W-1:0] tx_byte;
    bit              last;
    bit              miso;
  } tick_t;

  typedef struct {
    bit              sck;
    bit              mosi;
    bit              busy;
    bit              rx_valid;
    bit [BYTE_W-1:0] rx_byte;
    bit              rx_last;
  } pins_t;

  class spi_byte_scoreboard;
    pins_t                expected_pins[$];
    int unsigned          mismatches;
    bit [DELAY_W-1:0]     half_delay;
    bit [BYTE_W-1:0]      shift_q;
    bit [BITCNT_W-1:0]    bit_cnt;
    phase_t               phase_q;
    bit [DELAY_W-1:0]     ticks;
    bit                   active;
    bit                   sck_q;
    bit                   mosi_q;
    bit                   final_q;

    function new();
      mismatches = 0;
      half_delay = '0;
      shift_q = '0;
      bit_cnt = '0;
      phase_q = PH_SCK_LOW;
      ticks = '0;
      active = 1'b0;
      sck_q = 1'b1;
      mosi_q = 1'b1;
      final_q = 1'b0;
    endfunction

    function void set_half_delay(bit [DELAY_W-1:0] value);
      half_delay = value;
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction

    function void note_tick(tick_t t);
      pins_t p;
      p.rx_valid = 1'b0;
      p.rx_byte = '0;
      p.rx_last = 1'b0;
      if (!active) begin
        if (t.start) begin
          shift_q = t.present ? t.tx_byte : IDLE_BYTE;
          final_q = t.last;
          active = 1'b1;
          bit_cnt = '0;
          phase_q = PH_SCK_LOW;
          ticks = '0;
          sck_q = 1'b0;
        end
      end else if (ticks < half_delay) begin
        ticks = ticks + 1'b1;
      end else begin
        ticks = '0;
        case (phase_q)
          PH_SCK_LOW: begin
            phase_q = PH_MOSI;
            mosi_q = shift_q[BYTE_W-1];
          end
          PH_MOSI: begin
            phase_q = PH_SCK_HIGH;
            shift_q = shift_q << 1;
            sck_q = 1'b1;
          end
          PH_SCK_HIGH: begin
            phase_q = PH_SAMPLE;
            shift_q[0] = t.miso;
          end
          default: begin
            phase_q = PH_SCK_LOW;
            if (bit_cnt == LAST_BIT) begin
              active = 1'b0;
              bit_cnt = '0;
              p.rx_valid = 1'b1;
              p.rx_byte = shift_q;
              p.rx_last = final_q;
            end else begin
              bit_cnt = bit_cnt + 1'b1;
              sck_q = 1'b0;
            end
          end
        endcase
      end
      p.sck = sck_q;
      p.mosi = mosi_q;
      p.busy = active;
      expected_pins.push_back(p);
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_pins(pins_t got);
      pins_t exp_p;
      if (expected_pins.size() == 0) begin
        $display("%0t: result transfer with none expected, actual rx_byte %0h",
                 $time, got.rx_byte);
        mismatches++;
        return;
      end
      exp_p = expected_pins.pop_front();
      check_field("sck", exp_p.sck, got.sck);
      check_field("mosi", exp_p.mosi, got.mosi);
      check_field("busy_res", exp_p.busy, got.busy);
      check_field("rx_valid", exp_p.rx_valid, got.rx_valid);
      check_field("rx_byte", exp_p.rx_byte, got.rx_byte);
      check_field("rx_last", exp_p.rx_last, got.rx_last);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [DELAY_W-1:0]  cfg_half_delay;
  logic                in_valid;
  logic                in_stall;
  logic                in_start_req;
  logic                in_tx_present;
  logic [BYTE_W-1:0]   in_tx_byte;
  logic                in_last_byte;
  logic                in_miso;
  logic                out_valid;
  logic                out_stall;
  logic                out_sck;
  logic                out_mosi;
  logic                out_busy_res;
  logic                out_rx_valid;
  logic [BYTE_W-1:0]   out_rx_byte;
  logic                out_rx_last;

  spi_byte_scoreboard board;
  int unsigned        burst_left;

  spi_master_byte_shifter_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_half_delay (cfg_half_delay),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_tx_present  (in_tx_present),
    .in_tx_byte     (in_tx_byte),
    .in_last_byte   (in_last_byte),
    .in_miso        (in_miso),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sck        (out_sck),
    .out_mosi       (out_mosi),
    .out_busy_res   (out_busy_res),
    .out_rx_valid   (out_rx_valid),
    .out_rx_byte    (out_rx_byte),
    .out_rx_last    (out_rx_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_tick(tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_start_req <= t.start;
    in_tx_present <= t.present;
    in_tx_byte <= t.tx_byte;
    in_last_byte <= t.last;
    in_miso <= t.miso;
    do @(posedge clk); while (in_stall);
    board.note_tick(t);
  endtask

  function automatic tick_t random_tick(int unsigned start_pct);
    tick_t t;
    t.start = ($urandom_range(0, 99) < start_pct);
    t.present = ($urandom_range(0, 3) != 0);
    t.tx_byte = BYTE_W'($urandom_range(0, 255));
    t.last = 1'($urandom_range(0, 1));
    t.miso = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic run_random(int unsigned count, int unsigned start_pct);
    repeat (count) send_tick(random_tick(start_pct));
  endtask

  // Start tick, then 32 ticks with start requests held high so that every busy tick and
  // the completion tick carry an ignored start. At zero delay MISO bit b is sampled on
  // tick 31-4b.
  task automatic directed_byte(bit present, bit [BYTE_W-1:0] tx, bit last,
                               bit [BYTE_W-1:0] miso_bits);
    tick_t t;
    t.start = 1'b1;
    t.present = present;
    t.tx_byte = tx;
    t.last = last;
    t.miso = 1'b0;
    send_tick(t);
    for (int k = 1; k <= 32; k++) begin
      t = random_tick(100);
      t.miso = miso_bits[7 - ((k - 1) >> 2)];
      send_tick(t);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_half_delay(bit [DELAY_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_half_delay <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_half_delay(value);
  endtask

  initial begin : receiver
    pins_t       got;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold;
    out_stall <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.sck = out_sck;
        got.mosi = out_mosi;
        got.busy = out_busy_res;
        got.rx_valid = out_rx_valid;
        got.rx_byte = out_rx_byte;
        got.rx_last = out_rx_last;
        board.check_pins(got);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(100, 400);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 4);
        default: begin
          if (hold == 0) begin
            hold = out_stall ? $urandom_range(1, 10) : $urandom_range(5, 40);
            out_stall <= ~out_stall;
          end
          hold--;
        end
      endcase
    end
  end

  initial begin : stimulus
    tick_t t;
    board = new();
    burst_left = 0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_half_delay <= '0;
    in_valid <= 1'b0;
    in_start_req <= 1'b0;
    in_tx_present <= 1'b0;
    in_tx_byte <= '0;
    in_last_byte <= 1'b0;
    in_miso <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_half_delay(16'd0);
    run_random(3, 0);
    directed_byte(1'b0, 8'h00, 1'b0, 8'h00);
    directed_byte(1'b1, 8'h00, 1'b1, 8'hFF);
    directed_byte(1'b1, 8'hA5, 1'b0, 8'h5A);
    run_random(2, 0);
    directed_byte(1'b1, 8'hFF, 1'b1, 8'h81);
    run_random(320, 35);

    drain_results();
    write_half_delay(16'd1);
    run_random(300, 30);

    drain_results();
    write_half_delay(DELAY_W'($urandom_range(2, 5)));
    run_random(150, 30);
    drain_results();
    run_random(150, 30);

    // Longest phase: the byte stays in its first phase for the whole stretch, and the
    // following change to zero delay cuts the running phase short.
    drain_results();
    write_half_delay(16'hFFFF);
    t = random_tick(100);
    send_tick(t);
    run_random(150, 50);
    drain_results();
    write_half_delay(16'd0);
    run_random(150, 30);

    drain_results();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- spi_master_byte_shifter_unit.f -----
rtl/smbs_pkg.sv
rtl/smbs_front.sv
rtl/smbs_queue.sv
rtl/smbs_back.sv
rtl/spi_master_byte_shifter_unit.sv
dv/spi_master_byte_shifter_unit_test.sv
